// ===== rtl/cta_pkg.sv =====
// Shared types, operation codes and calendar helpers for the calendar time adjuster.
// No dependencies; the core module imports this package.
package cta_pkg;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    FUNC_LOAD   = 3'd0,
    FUNC_SECOND = 3'd1,
    FUNC_MINUTE = 3'd2,
    FUNC_HOUR   = 3'd3,
    FUNC_DAY    = 3'd4
  } func_t;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Field limits
  localparam logic [5:0] SEC_MAX    = 6'd59;
  localparam logic [5:0] MIN_MAX    = 6'd59;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [4:0] DAY_LONG   = 5'd31;
  localparam logic [4:0] DAY_SHORT  = 5'd30;
  localparam logic [4:0] FEB_LEAP   = 5'd29;
  localparam logic [4:0] FEB_COMMON = 5'd28;
  localparam logic [3:0] MONTH_FEB  = 4'd2;

  // Modular inverses of 25 and divisibility bounds for exact-division tests
  localparam logic [13:0] INV25_14  = 14'd7209;
  localparam logic [13:0] LIM25_14  = 14'd655;
  localparam logic [11:0] INV25_12  = 12'd3113;
  localparam logic [11:0] LIM25_12  = 12'd163;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] amount;
    logic [5:0]         load_second;
    logic [5:0]         load_minute;
    logic [4:0]         load_hour;
    logic [4:0]         load_day;
    logic [3:0]         load_month;
    logic [15:0]        load_year;
  } in_t;

  typedef struct packed {
    logic [5:0]  second_out;
    logic [5:0]  minute_out;
    logic [4:0]  hour_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
  } out_t;

  // Gregorian leap test; divisibility by 25 via multiply by the inverse
  function automatic logic is_leap(input logic [15:0] y);
    logic [27:0] p100;
    logic [23:0] p400;
    logic        div100;
    logic        div400;
    p100   = 28'(y[15:2]) * 28'(INV25_14);
    p400   = 24'(y[15:4]) * 24'(INV25_12);
    div100 = (y[1:0] == 2'd0) && (p100[13:0] <= LIM25_14);
    div400 = (y[3:0] == 4'd0) && (p400[11:0] <= LIM25_12);
    return ((y[1:0] == 2'd0) && !div100) || div400;
  endfunction

  // Days in a month; months outside 1..12 have 30 days
  function automatic logic [4:0] month_len(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    case (mo)
      4'd2:                                    len = leap ? FEB_LEAP : FEB_COMMON;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_LONG;
      default:                                 len = DAY_SHORT;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/calendar_time_adjuster_core.sv =====
// Calendar time adjuster core: holds date and time, loads it or steps it by a signed count.
// Depends on cta_pkg for payload types, operation codes and calendar helpers.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------
//  in       | input     | in_valid/in_stall| in_data  (cta_pkg::in_t)
//  out      | output    | out_valid/stall  | out_data (cta_pkg::out_t)
//
// After the transfer, a load passes its loaded fields to the output register; an add first makes
// |amount| unit steps, one unit step a cycle through the shared step unit (the carry
// chain second -> minute -> hour -> day/month/year settles within that cycle).
// One item is in work at a time; in_stall is high from transfer until the result
// enters the output register. out_stall holds the output register and, once the
// count is done, holds the sequencer too. Reset puts 00:00:00, day 1, month 1, year 0.
module calendar_time_adjuster_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cta_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cta_pkg::out_t  out_data
);
  import cta_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] count_r, count_nxt;
  logic [2:0]  unit_r, unit_nxt;
  logic        up_r, up_nxt;
  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;

  logic        accept;
  logic        out_free;
  logic [15:0] raw;
  logic [15:0] mag;
  logic        leap;
  logic        do_sec, do_min, do_hour, do_day;
  logic        wrap_sec, wrap_min, wrap_hour;
  logic [5:0]  st_sec, st_min;
  logic [4:0]  st_hour, st_day;
  logic [3:0]  st_month;
  logic [15:0] st_year;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Magnitude of the signed count
  assign raw = in_data.amount;
  assign mag = raw[15] ? (~raw + 16'd1) : raw;

  // Shared step unit: one unit step with carry or borrow into larger fields
  always_comb begin
    leap      = is_leap(year_r);
    st_sec    = sec_r;
    st_min    = min_r;
    st_hour   = hour_r;
    st_day    = day_r;
    st_month  = month_r;
    st_year   = year_r;
    wrap_sec  = up_r ? (sec_r >= SEC_MAX) : (sec_r == 6'd0);
    wrap_min  = up_r ? (min_r >= MIN_MAX) : (min_r == 6'd0);
    wrap_hour = up_r ? (hour_r >= HOUR_MAX) : (hour_r == 5'd0);
    do_sec    = (unit_r == FUNC_SECOND);
    do_min    = (unit_r == FUNC_MINUTE) || (do_sec && wrap_sec);
    do_hour   = (unit_r == FUNC_HOUR) || (do_min && wrap_min);
    do_day    = (unit_r == FUNC_DAY) || (do_hour && wrap_hour);
    if (do_sec) begin
      st_sec = up_r ? (wrap_sec ? 6'd0 : sec_r + 6'd1) : (wrap_sec ? SEC_MAX : sec_r - 6'd1);
    end
    if (do_min) begin
      st_min = up_r ? (wrap_min ? 6'd0 : min_r + 6'd1) : (wrap_min ? MIN_MAX : min_r - 6'd1);
    end
    if (do_hour) begin
      st_hour = up_r ? (wrap_hour ? 5'd0 : hour_r + 5'd1)
                     : (wrap_hour ? HOUR_MAX : hour_r - 5'd1);
    end
    if (do_day) begin
      if (up_r) begin
        if (day_r < month_len(month_r, leap)) begin
          st_day = day_r + 5'd1;
        end else if (month_r < MONTH_MAX) begin
          st_month = month_r + 4'd1;
          st_day   = 5'd1;
        end else begin
          st_month = 4'd1;
          st_day   = 5'd1;
          st_year  = year_r + 16'd1;
        end
      end else begin
        if (day_r > 5'd1) begin
          st_day = day_r - 5'd1;
        end else if (month_r > 4'd1) begin
          st_month = month_r - 4'd1;
          st_day   = month_len(month_r - 4'd1, leap);
        end else begin
          st_month = MONTH_MAX;
          st_day   = DAY_LONG;
          st_year  = year_r - 16'd1;
        end
      end
    end
  end

  // Sequencer: next state, counters, date fields and output register
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    unit_nxt      = unit_r;
    up_nxt        = up_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          unit_nxt  = in_data.func;
          up_nxt    = !raw[15];
          if (in_data.func == FUNC_LOAD) begin
            count_nxt = 16'd0;
            sec_nxt   = in_data.load_second;
            min_nxt   = in_data.load_minute;
            hour_nxt  = in_data.load_hour;
            day_nxt   = in_data.load_day;
            month_nxt = in_data.load_month;
            year_nxt  = in_data.load_year;
          end else if (in_data.func inside {FUNC_SECOND, FUNC_MINUTE, FUNC_HOUR, FUNC_DAY}) begin
            count_nxt = mag;
          end else begin
            count_nxt = 16'd0;
          end
        end
      end
      ST_RUN: begin
        if (count_r != 16'd0) begin
          // advance one unit
          count_nxt = count_r - 16'd1;
          sec_nxt   = st_sec;
          min_nxt   = st_min;
          hour_nxt  = st_hour;
          day_nxt   = st_day;
          month_nxt = st_month;
          year_nxt  = st_year;
        end else if (out_free) begin
          // hand the result to the output register
          state_nxt                = ST_IDLE;
          out_valid_nxt            = 1'b1;
          out_data_nxt.second_out  = sec_r;
          out_data_nxt.minute_out  = min_r;
          out_data_nxt.hour_out    = hour_r;
          out_data_nxt.day_out     = day_r;
          out_data_nxt.month_out   = month_r;
          out_data_nxt.year_out    = year_r;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and date registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= 16'd0;
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hour_r      <= 5'd0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    up_r       <= up_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for calendar_time_adjuster_core: loads, signed adds and unused codes,
// checked against an in-bench calendar predictor. Depends on rtl/cta_pkg.sv and the core.
module tb;
  import cta_pkg::*;

  // Operation codes the block leaves unused
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_MID   = 3'd6;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
  localparam int unsigned PRINT_CAP       = 40;
  localparam int unsigned PHASE_ITEMS     = 19;
  localparam int unsigned SETTLE_CYCLES   = 20;

  // Predicts the date and time after each transfer and holds the results still due
  class date_scoreboard;
    logic [5:0]  cur_sec;
    logic [5:0]  cur_min;
    logic [4:0]  cur_hour;
    logic [4:0]  cur_day;
    logic [3:0]  cur_month;
    logic [15:0] cur_year;
    out_t        due_q[$];
    int unsigned fail_count;

    function new();
      cur_sec    = '0;
      cur_min    = '0;
      cur_hour   = '0;
      cur_day    = 5'd1;
      cur_month  = 4'd1;
      cur_year   = '0;
      fail_count = 0;
    endfunction

    function bit year_is_leap(logic [15:0] y);
      int unsigned yy;
      yy = y;
      return ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
    endfunction

    function logic [4:0] days_in(logic [3:0] mo, logic [15:0] y);
      if (mo == MONTH_FEB) return year_is_leap(y) ? FEB_LEAP : FEB_COMMON;
      if (mo == 4'd1 || mo == 4'd3 || mo == 4'd5 || mo == 4'd7 || mo == 4'd8 ||
          mo == 4'd10 || mo == 4'd12) return DAY_LONG;
      return DAY_SHORT;
    endfunction

    // Advance or retreat one day, rolling month and year
    function void day_step(bit up);
      if (up) begin
        if (cur_day < days_in(cur_month, cur_year)) begin
          cur_day = cur_day + 1'b1;
        end else if (cur_month < MONTH_MAX) begin
          cur_month = cur_month + 1'b1;
          cur_day   = 5'd1;
        end else begin
          cur_month = 4'd1;
          cur_day   = 5'd1;
          cur_year  = cur_year + 1'b1;
        end
      end else begin
        if (cur_day > 5'd1) begin
          cur_day = cur_day - 1'b1;
        end else if (cur_month > 4'd1) begin
          cur_month = cur_month - 1'b1;
          cur_day   = days_in(cur_month, cur_year);
        end else begin
          cur_month = MONTH_MAX;
          cur_day   = DAY_LONG;
          cur_year  = cur_year - 1'b1;
        end
      end
    endfunction

    function void hour_step(bit up);
      if (up) begin
        if (cur_hour < HOUR_MAX) cur_hour = cur_hour + 1'b1;
        else begin
          cur_hour = '0;
          day_step(1'b1);
        end
      end else begin
        if (cur_hour > 0) cur_hour = cur_hour - 1'b1;
        else begin
          cur_hour = HOUR_MAX;
          day_step(1'b0);
        end
      end
    endfunction

    function void minute_step(bit up);
      if (up) begin
        if (cur_min < MIN_MAX) cur_min = cur_min + 1'b1;
        else begin
          cur_min = '0;
          hour_step(1'b1);
        end
      end else begin
        if (cur_min > 0) cur_min = cur_min - 1'b1;
        else begin
          cur_min = MIN_MAX;
          hour_step(1'b0);
        end
      end
    endfunction

    function void second_step(bit up);
      if (up) begin
        if (cur_sec < SEC_MAX) cur_sec = cur_sec + 1'b1;
        else begin
          cur_sec = '0;
          minute_step(1'b1);
        end
      end else begin
        if (cur_sec > 0) cur_sec = cur_sec - 1'b1;
        else begin
          cur_sec = SEC_MAX;
          minute_step(1'b0);
        end
      end
    endfunction

    // Apply one accepted transfer; return the number of unit steps it costs
    function int unsigned note_input(in_t it);
      logic [15:0] raw;
      bit          up;
      int unsigned count;
      out_t        res;
      raw   = it.amount;
      up    = ~raw[15];
      count = up ? raw : (32'h10000 - raw);
      if (it.func == FUNC_LOAD) begin
        cur_sec   = it.load_second;
        cur_min   = it.load_minute;
        cur_hour  = it.load_hour;
        cur_day   = it.load_day;
        cur_month = it.load_month;
        cur_year  = it.load_year;
        count     = 0;
      end else if (it.func >= FUNC_SECOND && it.func <= FUNC_DAY) begin
        for (int unsigned k = 0; k < count; k++) begin
          case (it.func)
            FUNC_SECOND: second_step(up);
            FUNC_MINUTE: minute_step(up);
            FUNC_HOUR:   hour_step(up);
            default:     day_step(up);
          endcase
        end
      end else begin
        count = 0;
      end
      res.second_out = cur_sec;
      res.minute_out = cur_min;
      res.hour_out   = cur_hour;
      res.day_out    = cur_day;
      res.month_out  = cur_month;
      res.year_out   = cur_year;
      due_q.push_back(res);
      return count;
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    task report(string msg);
      if (fail_count < PRINT_CAP) $display("MISMATCH: %s", msg);
      fail_count++;
    endtask

    // Compare one result transfer with the oldest prediction
    task check_result(out_t got);
      out_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result with nothing due: %p", got));
      end else begin
        want = due_q.pop_front();
        if (got.second_out !== want.second_out)
          report($sformatf("second got %0d want %0d", got.second_out, want.second_out));
        if (got.minute_out !== want.minute_out)
          report($sformatf("minute got %0d want %0d", got.minute_out, want.minute_out));
        if (got.hour_out !== want.hour_out)
          report($sformatf("hour got %0d want %0d", got.hour_out, want.hour_out));
        if (got.day_out !== want.day_out)
          report($sformatf("day got %0d want %0d", got.day_out, want.day_out));
        if (got.month_out !== want.month_out)
          report($sformatf("month got %0d want %0d", got.month_out, want.month_out));
        if (got.year_out !== want.year_out)
          report($sformatf("year got %0d want %0d", got.year_out, want.year_out));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  date_scoreboard sb = new();
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  longint         cycle_count;
  longint         cycle_limit;

  calendar_time_adjuster_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drive result-side backpressure
  initial out_stall = 1'b0;
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_t load_item(int unsigned s, int unsigned m, int unsigned h,
                                    int unsigned d, int unsigned mo, int unsigned y);
    in_t it;
    it.func        = FUNC_LOAD;
    it.amount      = 16'($urandom());
    it.load_second = 6'(s);
    it.load_minute = 6'(m);
    it.load_hour   = 5'(h);
    it.load_day    = 5'(d);
    it.load_month  = 4'(mo);
    it.load_year   = 16'(y);
    return it;
  endfunction

  function automatic in_t step_item(logic [2:0] f, int amt);
    in_t it;
    it             = load_item($urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom(), $urandom());
    it.func        = f;
    it.amount      = 16'(amt);
    return it;
  endfunction

  // Lean toward the ends of a field's range
  function automatic int unsigned edge_pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 2))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2:       return 1900;
      3:       return 2000;
      4:       return 2100;
      5:       return 2400;
      6:       return 4 * $urandom_range(0, 16383);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return int'($urandom_range(0, 10)) - 5;
    if (r < 85) return int'($urandom_range(0, 800)) - 400;
    if (r < 97) return int'($urandom_range(0, 10000)) - 5000;
    return int'(16'($urandom()) ^ 16'h8000) - 32768;
  endfunction

  // Mostly adds, with loads near calendar edges; some raw loads and unused codes
  function automatic in_t rand_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6)
      return load_item($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom());
    if (r < 25)
      return load_item(edge_pick(0, SEC_MAX), edge_pick(0, MIN_MAX), edge_pick(0, HOUR_MAX),
                       $urandom_range(0, 1) ? $urandom_range(28, 31) : $urandom_range(1, 31),
                       edge_pick(1, MONTH_MAX), pick_year());
    if (r < 32)
      return step_item(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), pick_amount());
    return step_item(3'($urandom_range(FUNC_SECOND, FUNC_DAY)), pick_amount());
  endfunction

  // Present one item after a random gap and hold it until the transfer
  task send_item(in_t it);
    int unsigned steps;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    steps = sb.note_input(it);
    cycle_limit += 4 * (longint'(steps) + 2) + 400;
    @(negedge clk);
  endtask

  // Drop valid and wait for every predicted result
  task drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    cycle_count   = 0;
    cycle_limit   = 5000;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero count, borrow from reset into year 65535, carry back to year 0
    send_item(step_item(FUNC_SECOND, 0));
    send_item(step_item(FUNC_SECOND, -1));
    send_item(step_item(FUNC_SECOND, 1));
    // Year wrap upward from the last second of year 65535
    send_item(load_item(59, 59, 23, 31, 12, 65535));
    send_item(step_item(FUNC_SECOND, 1));
    // Century and 400-year leap rules
    send_item(load_item(0, 0, 0, 28, 2, 1900));
    send_item(step_item(FUNC_DAY, 1));
    send_item(load_item(0, 0, 0, 28, 2, 2000));
    send_item(step_item(FUNC_DAY, 1));
    send_item(load_item(0, 0, 0, 1, 3, 2100));
    send_item(step_item(FUNC_DAY, -1));
    // Year 0 is a leap year
    send_item(load_item(0, 0, 0, 1, 3, 0));
    send_item(step_item(FUNC_HOUR, -24));
    // Out-of-range fields stored unchecked, then stepped both ways
    send_item(load_item(63, 63, 31, 31, 15, 65535));
    send_item(step_item(FUNC_SECOND, -1));
    send_item(step_item(FUNC_SECOND, 1));
    send_item(load_item(0, 0, 0, 0, 0, 5));
    send_item(step_item(FUNC_DAY, -1));
    send_item(load_item(0, 0, 0, 30, 13, 7));
    send_item(step_item(FUNC_DAY, 1));
    // Unused codes leave the state alone
    send_item(step_item(FUNC_SPARE_FIRST, 100));
    send_item(step_item(FUNC_SPARE_MID, -100));
    send_item(step_item(FUNC_SPARE_LAST, 7));
    // Largest counts in both directions
    send_item(step_item(FUNC_DAY, 32767));
    send_item(step_item(FUNC_MINUTE, -32768));

    // Random phases: free running, sender gaps, receiver stalls, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (PHASE_ITEMS) send_item(rand_item());
      // Hold off the sender until the block is empty once
      if (phase == 1) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
